FILE: rtl/core/tpq_pkg.sv
// Package for the two-class priority queue unit.
// Holds the shared constants, the status and mode codes and the ring control structs.
// No dependencies.
`timescale 1ns / 1ps

package tpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TAG_BITS_DEF    = 16;
  localparam int AGE_W           = 7;
  localparam int PCOUNT_W        = 6;
  localparam int TCOUNT_W        = 7;

  localparam logic [AGE_W-1:0] THRESHOLD_RESET = 7'd65;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_SERVE   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_sts_t;

endpackage

FILE: rtl/core/tpq_if.sv
// Channel interfaces for the two-class priority queue unit: request and response words.
// Each carries valid, ready and the payload. Depends on tpq_pkg.
`timescale 1ns / 1ps

interface tpq_req_if #(
  parameter int TAG_BITS = tpq_pkg::TAG_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [TAG_BITS-1:0]        customer_tag;
  logic [tpq_pkg::AGE_W-1:0]  customer_age;

  modport source (output valid, mode, customer_tag, customer_age, input ready);
  modport sink   (input valid, mode, customer_tag, customer_age, output ready);
endinterface

interface tpq_rsp_if #(
  parameter int TAG_BITS = tpq_pkg::TAG_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic                          served;
  logic [TAG_BITS-1:0]           served_tag;
  logic [tpq_pkg::AGE_W-1:0]     served_age;
  logic                          from_priority;
  logic [1:0]                    status;
  logic [tpq_pkg::PCOUNT_W-1:0]  priority_count;
  logic [tpq_pkg::PCOUNT_W-1:0]  normal_count;
  logic [tpq_pkg::TCOUNT_W-1:0]  total_count;

  modport source (output valid, served, served_tag, served_age, from_priority, status,
                  priority_count, normal_count, total_count, input ready);
  modport sink   (input valid, served, served_tag, served_age, from_priority, status,
                  priority_count, normal_count, total_count, output ready);
endinterface

FILE: rtl/core/tpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold the last read word until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/tpq_ring.sv
// One ring-buffer FIFO: head and tail pointers, fill count and its entry RAM.
// Depends on tpq_pkg and tpq_ram. Pop data is registered and holds until the next pop.
`timescale 1ns / 1ps

module tpq_ring #(
  parameter int DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = tpq_pkg::TAG_BITS_DEF + tpq_pkg::AGE_W,
  localparam int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  tpq_pkg::ring_cmd_t cmd,
  input  logic [WIDTH-1:0]   wr_data,
  output logic [WIDTH-1:0]   rd_data,
  output logic [FILL_W-1:0]  fill_next,
  output tpq_pkg::ring_sts_t sts
);
  import tpq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [FILL_W-1:0] fill;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign sts.full  = (fill == FILL_W'(DEPTH));
  assign sts.empty = (fill == '0);

  always_comb begin
    fill_next = fill;
    if (cmd.push && !cmd.pop) begin
      fill_next = fill + 1'b1;
    end else if (cmd.pop && !cmd.push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (cmd.push) begin
        tail <= ptr_inc(tail);
      end
      if (cmd.pop) begin
        head <= ptr_inc(head);
      end
    end
  end

  tpq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_en   (cmd.pop),
    .rd_addr (head),
    .rd_data (rd_data)
  );

endmodule

FILE: rtl/core/two_class_priority_queue_unit.sv
// Two-class strict-priority queue unit.
//
// req carries one word per operation: mode selects enqueue (tag and age) or serve.
// An enqueued age at or above the age threshold goes to the priority FIFO, any
// other age to the normal FIFO; an enqueue to a full FIFO is dropped and flagged.
// A serve pops the priority FIFO first, then the normal FIFO, else reports empty.
// rsp returns exactly one word per request with the served entry, a status code
// and the fill counts of both FIFOs after the operation.
// cfg_we / cfg_wdata write the 7-bit age threshold; write it only while idle.
//
// The response is registered: it is valid in the cycle after request acceptance.
// One request is taken every cycle unless rsp stalls: pointers and counts update at
// acceptance, and the entry RAM read issued then lands with the response register.
// When rsp stalls, the response word holds and req.ready drops until it is taken.
// Synchronous reset empties both FIFOs, clears the response valid flag and loads
// the threshold with 65; entry RAMs are not cleared, so there is no clearing pass.
// Depends on tpq_pkg, tpq_if and tpq_ring.
`timescale 1ns / 1ps

module two_class_priority_queue_unit #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = tpq_pkg::TAG_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  tpq_req_if.sink                   req,
  tpq_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [tpq_pkg::AGE_W-1:0] cfg_wdata
);
  import tpq_pkg::*;

  localparam int ENTRY_W = TAG_BITS + AGE_W;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W   = (FILL_W > TCOUNT_W) ? FILL_W + 1 : TCOUNT_W + 1;

  logic [AGE_W-1:0] age_threshold;

  ring_cmd_t           pri_cmd, nrm_cmd;
  ring_sts_t           pri_sts, nrm_sts;
  logic [ENTRY_W-1:0]  pri_rd, nrm_rd;
  logic [FILL_W-1:0]   pri_fill_next, nrm_fill_next;

  logic accept;
  logic to_priority;
  logic [ENTRY_W-1:0] entry_in;

  // response register
  logic                 out_valid;
  logic                 res_served;
  logic                 res_from_pri;
  status_t              res_status;
  logic [PCOUNT_W-1:0]  res_pcount;
  logic [PCOUNT_W-1:0]  res_ncount;
  logic [TCOUNT_W-1:0]  res_tcount;

  status_t              status_next;
  logic [EXT_W-1:0]     pri_ext, nrm_ext, sum_ext;
  logic [ENTRY_W-1:0]   served_entry;

  assign req.ready   = !out_valid || rsp.ready;
  assign accept      = req.valid && req.ready;
  assign to_priority = (req.customer_age >= age_threshold);
  assign entry_in    = {req.customer_tag, req.customer_age};

  always_comb begin
    pri_cmd     = '0;
    nrm_cmd     = '0;
    status_next = STATUS_OK;
    if (req.mode == MODE_ENQUEUE) begin
      if (to_priority) begin
        pri_cmd.push = accept && !pri_sts.full;
        if (pri_sts.full) begin
          status_next = STATUS_DROPPED;
        end
      end else begin
        nrm_cmd.push = accept && !nrm_sts.full;
        if (nrm_sts.full) begin
          status_next = STATUS_DROPPED;
        end
      end
    end else begin
      // strict priority: normal FIFO only when the priority FIFO is empty
      if (!pri_sts.empty) begin
        pri_cmd.pop = accept;
      end else if (!nrm_sts.empty) begin
        nrm_cmd.pop = accept;
      end else begin
        status_next = STATUS_EMPTY;
      end
    end
  end

  assign pri_ext = EXT_W'(pri_fill_next);
  assign nrm_ext = EXT_W'(nrm_fill_next);
  assign sum_ext = pri_ext + nrm_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      age_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.ready) begin
      out_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_served   <= pri_cmd.pop || nrm_cmd.pop;
      res_from_pri <= pri_cmd.pop;
      res_status   <= status_next;
      res_pcount   <= pri_ext[PCOUNT_W-1:0];
      res_ncount   <= nrm_ext[PCOUNT_W-1:0];
      res_tcount   <= sum_ext[TCOUNT_W-1:0];
    end
  end

  tpq_ring #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_pri_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pri_cmd),
    .wr_data   (entry_in),
    .rd_data   (pri_rd),
    .fill_next (pri_fill_next),
    .sts       (pri_sts)
  );

  tpq_ring #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_nrm_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (nrm_cmd),
    .wr_data   (entry_in),
    .rd_data   (nrm_rd),
    .fill_next (nrm_fill_next),
    .sts       (nrm_sts)
  );

  // RAM read words hold until the next pop, which waits for this word to leave
  assign served_entry = !res_served ? '0 : (res_from_pri ? pri_rd : nrm_rd);

  assign rsp.valid          = out_valid;
  assign rsp.served         = res_served;
  assign rsp.served_tag     = served_entry[ENTRY_W-1:AGE_W];
  assign rsp.served_age     = served_entry[AGE_W-1:0];
  assign rsp.from_priority  = res_served && res_from_pri;
  assign rsp.status         = res_status;
  assign rsp.priority_count = res_pcount;
  assign rsp.normal_count   = res_ncount;
  assign rsp.total_count    = res_tcount;

endmodule

FILE: rtl/core/tpq_checker.sv
// Port-level checker for the two-class priority queue unit, bound to the top level.
// Depends on tpq_pkg.
`timescale 1ns / 1ps

module tpq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          served,
  input logic                          from_priority,
  input logic [1:0]                    status,
  input logic [tpq_pkg::PCOUNT_W-1:0]  priority_count,
  input logic [tpq_pkg::PCOUNT_W-1:0]  normal_count,
  input logic [tpq_pkg::TCOUNT_W-1:0]  total_count
);
  import tpq_pkg::*;

  logic [PCOUNT_W-1:0] count_sum;
  assign count_sum = priority_count + normal_count;

  // an accepted request always yields a response word on the next cycle
  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no response after an accepted request");

  a_served_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && served |-> status == STATUS_OK)
    else $error("served word carries a failure status");

  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> total_count[PCOUNT_W-1:0] == count_sum)
    else $error("total count disagrees with the queue counts");

  // a normal-queue serve means the priority queue was and stays empty
  a_strict_priority: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && served && !from_priority |-> priority_count == '0)
    else $error("normal queue served while priority queue held entries");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(total_count))
    else $error("response word changed while stalled");

endmodule

bind two_class_priority_queue_unit tpq_checker u_tpq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .served         (rsp.served),
  .from_priority  (rsp.from_priority),
  .status         (rsp.status),
  .priority_count (rsp.priority_count),
  .normal_count   (rsp.normal_count),
  .total_count    (rsp.total_count)
);

FILE: tb/tpq_reply_checker.sv
`timescale 1ns / 1ps
// Response checker for two_class_priority_queue_unit: mirrors both FIFOs and the age
// threshold from the accepted request words and compares every response word in order.
// Depends on tpq_pkg and tpq_if.

module tpq_reply_checker (
  input  logic                      clk,
  input  logic                      rst,
  tpq_req_if                        req,
  tpq_rsp_if                        rsp,
  input  logic                      cfg_we,
  input  logic [tpq_pkg::AGE_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        outstanding
);
  import tpq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int TW    = TAG_BITS_DEF;

  typedef struct packed {
    logic [TW-1:0]    tag;
    logic [AGE_W-1:0] age;
  } customer_t;

  typedef struct packed {
    logic                served;
    logic [TW-1:0]       tag;
    logic [AGE_W-1:0]    age;
    logic                from_priority;
    status_t             status;
    logic [PCOUNT_W-1:0] pri_count;
    logic [PCOUNT_W-1:0] nrm_count;
    logic [TCOUNT_W-1:0] all_count;
  } reply_t;

  customer_t        pri_slots [DEPTH];
  customer_t        nrm_slots [DEPTH];
  int               pri_head, pri_tail, pri_fill;
  int               nrm_head, nrm_tail, nrm_fill;
  logic [AGE_W-1:0] threshold;
  reply_t           awaited_replies [$];
  int               errors = 0;

  // Advance the mirrored FIFOs by one request word and return the reply it must give.
  function automatic reply_t apply_request(logic mode, logic [TW-1:0] tag,
                                           logic [AGE_W-1:0] age);
    reply_t    r;
    customer_t c;
    r        = '0;
    r.status = STATUS_OK;
    if (mode == MODE_ENQUEUE) begin
      if (age >= threshold) begin
        if (pri_fill == DEPTH) begin
          r.status = STATUS_DROPPED;
        end else begin
          pri_slots[pri_tail] = {tag, age};
          pri_tail = (pri_tail == DEPTH - 1) ? 0 : pri_tail + 1;
          pri_fill++;
        end
      end else begin
        if (nrm_fill == DEPTH) begin
          r.status = STATUS_DROPPED;
        end else begin
          nrm_slots[nrm_tail] = {tag, age};
          nrm_tail = (nrm_tail == DEPTH - 1) ? 0 : nrm_tail + 1;
          nrm_fill++;
        end
      end
    end else if (pri_fill > 0) begin
      c = pri_slots[pri_head];
      pri_head = (pri_head == DEPTH - 1) ? 0 : pri_head + 1;
      pri_fill--;
      r.served        = 1'b1;
      r.tag           = c.tag;
      r.age           = c.age;
      r.from_priority = 1'b1;
    end else if (nrm_fill > 0) begin
      c = nrm_slots[nrm_head];
      nrm_head = (nrm_head == DEPTH - 1) ? 0 : nrm_head + 1;
      nrm_fill--;
      r.served = 1'b1;
      r.tag    = c.tag;
      r.age    = c.age;
    end else begin
      r.status = STATUS_EMPTY;
    end
    r.pri_count = PCOUNT_W'(pri_fill);
    r.nrm_count = PCOUNT_W'(nrm_fill);
    r.all_count = TCOUNT_W'(pri_fill + nrm_fill);
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      pri_head  = 0;
      pri_tail  = 0;
      pri_fill  = 0;
      nrm_head  = 0;
      nrm_tail  = 0;
      nrm_fill  = 0;
      threshold = THRESHOLD_RESET;
      awaited_replies.delete();
    end else begin
      // Retire the response word first: the request taken at this edge answers later.
      if (rsp.valid && rsp.ready) begin
        if (awaited_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected response word, expected none actual status %0h",
                   $time, rsp.status);
        end else begin
          want = awaited_replies.pop_front();
          check_field("served", want.served, rsp.served);
          check_field("served_tag", want.tag, rsp.served_tag);
          check_field("served_age", want.age, rsp.served_age);
          check_field("from_priority", want.from_priority, rsp.from_priority);
          check_field("status", want.status, rsp.status);
          check_field("priority_count", want.pri_count, rsp.priority_count);
          check_field("normal_count", want.nrm_count, rsp.normal_count);
          check_field("total_count", want.all_count, rsp.total_count);
        end
      end
      if (req.valid && req.ready)
        awaited_replies.push_back(apply_request(req.mode, req.customer_tag,
                                                req.customer_age));
      if (cfg_we)
        threshold = cfg_wdata;
    end
    mismatches  <= errors;
    outstanding <= awaited_replies.size();
  end

endmodule

FILE: tb/two_class_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// Top of the two_class_priority_queue_unit testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on tpq_pkg, tpq_if and tpq_reply_checker.

module two_class_priority_queue_unit_tb;
  import tpq_pkg::*;

  localparam int TW          = TAG_BITS_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int LONG_HOLD   = 200;
  localparam int CYCLE_LIMIT = 600000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [AGE_W-1:0] cfg_wdata;
  int               mismatches;
  int               outstanding;
  int               hold_requests = 0;
  int               holds_done = 0;
  logic [AGE_W-1:0] cur_threshold;

  tpq_req_if #(.TAG_BITS(TW)) req ();
  tpq_rsp_if #(.TAG_BITS(TW)) rsp ();

  two_class_priority_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH_DEF),
    .TAG_BITS(TW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  tpq_reply_checker chk (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_cycles();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Favor ages right at the threshold boundary and the field extremes.
  function automatic logic [AGE_W-1:0] pick_age();
    case ($urandom_range(0, 7))
      0: return cur_threshold;
      1: return cur_threshold - 1'b1;
      2: return '0;
      3: return '1;
      default: return AGE_W'($urandom);
    endcase
  endfunction

  task automatic offer(input logic mode, input logic [TW-1:0] tag,
                       input logic [AGE_W-1:0] age);
    req.valid        <= 1'b1;
    req.mode         <= mode;
    req.customer_tag <= tag;
    req.customer_age <= age;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic pause(input int cycles);
    req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the request side until every response word has come back.
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  // Response side: random stall stretches, calm stretches, and requested long holds.
  initial begin
    int stall_left;
    int stretch_left;
    bit calm;
    stall_left   = 0;
    stretch_left = 0;
    calm         = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        rsp.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        holds_done++;
        rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(20, 80);
          calm         = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        if (!calm && $urandom_range(0, 3) == 0)
          stall_left = gap_cycles();
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int  enq_pct;
    bit  calm;
    logic mode;
    enq_pct = 50;
    calm    = 1'b0;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.mode         <= MODE_ENQUEUE;
    req.customer_tag <= '0;
    req.customer_age <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    cur_threshold = THRESHOLD_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty serve, extremes, both sides of the threshold, priority order.
    offer(MODE_SERVE, '1, '1);
    offer(MODE_ENQUEUE, '0, '0);
    offer(MODE_ENQUEUE, '1, '1);
    offer(MODE_ENQUEUE, 16'h1234, THRESHOLD_RESET);
    offer(MODE_ENQUEUE, 16'h5555, THRESHOLD_RESET - 1'b1);
    offer(MODE_ENQUEUE, 16'hAAAA, THRESHOLD_RESET + 1'b1);
    offer(MODE_SERVE, '0, '0);
    offer(MODE_ENQUEUE, 16'h8001, 7'h40);
    offer(MODE_SERVE, '0, '0);
    offer(MODE_SERVE, '0, '0);
    offer(MODE_SERVE, '0, '0);
    offer(MODE_SERVE, '0, '0);
    offer(MODE_SERVE, '0, '0);
    offer(MODE_SERVE, '0, '0);
    offer(MODE_ENQUEUE, 16'h7FFF, '1);
    offer(MODE_ENQUEUE, 16'h0001, '0);
    offer(MODE_SERVE, 16'hFFFF, '1);
    offer(MODE_SERVE, '0, '0);
    offer(MODE_SERVE, '0, '0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: cur_threshold = '0;
          2: cur_threshold = '1;
          3: cur_threshold = 7'd1;
          4: cur_threshold = 7'd126;
          7: cur_threshold = THRESHOLD_RESET;
          default: cur_threshold = AGE_W'($urandom);
        endcase
        cfg_we    <= 1'b1;
        cfg_wdata <= cur_threshold;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      // Stall the response side for a long stretch while requests keep coming.
      if (p == 1)
        hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 45 == 0) begin
          case ($urandom_range(0, 2))
            0: enq_pct = 90;
            1: enq_pct = 50;
            default: enq_pct = 10;
          endcase
          calm = ($urandom_range(0, 2) == 0);
        end
        mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_SERVE;
        offer(mode, TW'($urandom), (mode == MODE_ENQUEUE) ? pick_age() : AGE_W'($urandom));
        if (!calm && $urandom_range(0, 3) == 0)
          pause(gap_cycles());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: two_class_priority_queue_unit.f
rtl/core/tpq_pkg.sv
rtl/core/tpq_if.sv
rtl/core/tpq_ram.sv
rtl/core/tpq_ring.sv
rtl/core/two_class_priority_queue_unit.sv
rtl/core/tpq_checker.sv
tb/tpq_reply_checker.sv
tb/two_class_priority_queue_unit_tb.sv
